// File: hw/rtl/pcmrms_pkg.sv
package pcmrms_pkg;

  localparam int unsigned MagW       = 16;
  localparam int unsigned SqW        = 2 * MagW;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pcm_in_t;

  typedef struct packed {
    logic [15:0] peak_level;
    logic [23:0] rms_level;
    logic [16:0] sample_total;
    logic        count_overflow;
  } pcm_res_t;

  typedef struct packed {
    logic push;
    logic last_pend;
  } front_stat_t;

endpackage

// File: hw/rtl/pcmrms_front.sv
module pcmrms_front import pcmrms_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned CNT_W       = 17,
  parameter int unsigned SUM_W       = 47
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  pcm_in_t          in_i,
  output front_stat_t      stat_o,
  output logic [MagW-1:0]  seg_peak_o,
  output logic [SUM_W-1:0] seg_sum_o,
  output logic [CNT_W-1:0] seg_cnt_o,
  output logic             seg_ovf_o
);

  logic [7:0]       held_q;
  logic             lowv_q;
  logic [MagW-1:0]  peak_q, peak_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;

  logic             p_take_q, p_last_q;
  logic [MagW-1:0]  p_mag_q, p_peak_q;
  logic [CNT_W-1:0] p_cnt_q;
  logic             p_ovf_q;
  logic [SUM_W-1:0] sum_q, sum_d;

  logic [15:0]      raw;
  logic [MagW-1:0]  mag;
  logic             room;
  logic             take;
  logic [SqW-1:0]   sq;

  assign raw  = {in_i.data_byte, held_q};
  assign mag  = raw[15] ? MagW'(~raw + 16'd1) : MagW'(raw);
  assign room = cnt_q < CNT_W'(MAX_SAMPLES);
  assign take = acc_i && lowv_q && room;

  always_comb begin
    peak_d = (take && (mag > peak_q)) ? mag : peak_q;
    cnt_d  = cnt_q + CNT_W'(take);
    ovf_d  = ovf_q | (acc_i && lowv_q && !room);
  end

  assign sq    = p_mag_q * p_mag_q;
  assign sum_d = sum_q + (p_take_q ? SUM_W'(sq) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      lowv_q   <= 1'b0;
      peak_q   <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      p_take_q <= 1'b0;
      p_last_q <= 1'b0;
      p_mag_q  <= '0;
      p_peak_q <= '0;
      p_cnt_q  <= '0;
      p_ovf_q  <= 1'b0;
      sum_q    <= '0;
    end else begin
      p_take_q <= take;
      p_last_q <= acc_i && in_i.last_byte;
      if (acc_i) begin
        p_mag_q <= mag;
        if (!lowv_q) begin
          held_q <= in_i.data_byte;
        end
        if (in_i.last_byte) begin
          p_peak_q <= peak_d;
          p_cnt_q  <= cnt_d;
          p_ovf_q  <= ovf_d;
          lowv_q   <= 1'b0;
          peak_q   <= '0;
          cnt_q    <= '0;
          ovf_q    <= 1'b0;
        end else begin
          lowv_q <= !lowv_q;
          peak_q <= peak_d;
          cnt_q  <= cnt_d;
          ovf_q  <= ovf_d;
        end
      end
      sum_q <= p_last_q ? '0 : sum_d;
    end
  end

  assign stat_o.push      = p_last_q;
  assign stat_o.last_pend = p_last_q;
  assign seg_peak_o       = p_peak_q;
  assign seg_sum_o        = sum_d;
  assign seg_cnt_o        = p_cnt_q;
  assign seg_ovf_o        = p_ovf_q;

endmodule

// File: hw/rtl/pcmrms_queue.sv
module pcmrms_queue import pcmrms_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  logic [W-1:0]               wdata_i,
  input  logic                       rd_i,
  output logic [W-1:0]               rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH+1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_rd;

  assign do_rd = rd_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH-1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH-1)) ? '0 : rptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(wr_i) - CntW'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// File: hw/rtl/pcmrms_back.sv
module pcmrms_back import pcmrms_pkg::*; #(
  parameter int unsigned CNT_W             = 17,
  parameter int unsigned SUM_W             = 47,
  parameter int unsigned RMS_FRACTION_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic [MagW-1:0]  seg_peak_i,
  input  logic [SUM_W-1:0] seg_sum_i,
  input  logic [CNT_W-1:0] seg_cnt_i,
  input  logic             seg_ovf_i,
  input  logic             pop_i,
  output logic             empty_o,
  output pcm_res_t         res_o
);

  localparam int unsigned NumW  = SUM_W + 2 * RMS_FRACTION_BITS;
  localparam int unsigned RootW = (NumW + 1) / 2;
  localparam int unsigned StepW = $clog2(NumW + 1);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_SQRT, B_HOLD} bstate_e;

  bstate_e          state_q;
  logic [NumW-1:0]  num_q;
  logic [CNT_W-1:0] rem_q, den_q;
  logic [2*RootW-1:0] rad_q;
  logic [RootW-1:0] root_q;
  logic [RootW:0]   srem_q;
  logic [StepW-1:0] step_q;
  logic [MagW-1:0]  peak_q;
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q;
  logic [23:0]      rms_q;
  logic             res_v_q;
  pcm_res_t         res_q;

  logic [CNT_W:0]   r2;
  logic             dge;
  logic [CNT_W:0]   r2_sub;
  logic [RootW+2:0] t, trial;
  logic             sge;
  logic [RootW+2:0] t_sub;
  logic [RootW-1:0] root_n;
  logic             out_free;

  assign r2     = {rem_q, num_q[NumW-1]};
  assign dge    = r2 >= {1'b0, den_q};
  assign r2_sub = r2 - {1'b0, den_q};

  assign t      = {srem_q, rad_q[2*RootW-1 -: 2]};
  assign trial  = (RootW+3)'({root_q, 2'b01});
  assign sge    = t >= trial;
  assign t_sub  = t - trial;
  assign root_n = {root_q[RootW-2:0], sge};

  assign out_free = !res_v_q || pop_i;
  assign q_pop_o  = (state_q == B_IDLE) && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      num_q   <= '0;
      rem_q   <= '0;
      den_q   <= '0;
      rad_q   <= '0;
      root_q  <= '0;
      srem_q  <= '0;
      step_q  <= '0;
      peak_q  <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      rms_q   <= '0;
      res_v_q <= 1'b0;
      res_q   <= '0;
    end else begin
      if (pop_i && res_v_q) begin
        res_v_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            num_q  <= NumW'(seg_sum_i) << (2 * RMS_FRACTION_BITS);
            den_q  <= seg_cnt_i;
            rem_q  <= '0;
            step_q <= '0;
            peak_q <= seg_peak_i;
            cnt_q  <= seg_cnt_i;
            ovf_q  <= seg_ovf_i;
            rms_q  <= '0;
            state_q <= (seg_cnt_i == '0) ? B_HOLD : B_DIV;
          end
        end
        B_DIV: begin
          num_q  <= {num_q[NumW-2:0], dge};
          rem_q  <= dge ? CNT_W'(r2_sub) : CNT_W'(r2);
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(NumW-1)) begin
            rad_q   <= (2*RootW)'({num_q[NumW-2:0], dge});
            root_q  <= '0;
            srem_q  <= '0;
            step_q  <= '0;
            state_q <= B_SQRT;
          end
        end
        B_SQRT: begin
          rad_q  <= rad_q << 2;
          root_q <= root_n;
          srem_q <= sge ? (RootW+1)'(t_sub) : (RootW+1)'(t);
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(RootW-1)) begin
            rms_q   <= 24'(root_n);
            state_q <= B_HOLD;
          end
        end
        B_HOLD: begin
          if (out_free) begin
            res_v_q              <= 1'b1;
            res_q.peak_level     <= peak_q;
            res_q.rms_level      <= rms_q;
            res_q.sample_total   <= 17'(cnt_q);
            res_q.count_overflow <= ovf_q;
            state_q              <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign empty_o = !res_v_q;
  assign res_o   = res_q;

endmodule

// File: hw/rtl/pcm16_peak_rms_meter_unit.sv
// PCM16 peak / RMS level meter.
// Input queue port: push with in_i (data_byte, last_byte); a byte is taken
// when push is high and full is low. Bytes pair little-endian into signed
// samples; last_byte closes the segment and yields one result item.
// Result queue port: res_o is valid while empty is low and is taken when
// pop is high. Fields: peak_level, rms_level (8 fraction bits), sample_total,
// count_overflow.
// Throughput: one byte per cycle while full is low. Each segment end runs a
// bit-serial divide and a bit-serial square root in the back unit; a segment
// with no whole sample skips both.
// A two-entry queue holds finished segment totals, so bytes keep flowing
// while the back unit works. full rises when that queue, plus a segment
// total about to be written, reaches two entries; a stalled receiver ends up
// holding off pushes this way once the queue has filled.
// Reset (rst_ni low, asynchronous) clears all segment totals and queues.
module pcm16_peak_rms_meter_unit import pcmrms_pkg::*; #(
  parameter int unsigned MAX_SAMPLES       = 65536,
  parameter int unsigned RMS_FRACTION_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  pcm_in_t  in_i,
  output logic     empty,
  input  logic     pop,
  output pcm_res_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW = CntW + 30;
  localparam int unsigned QW   = MagW + SumW + CntW + 1;
  localparam int unsigned QCW  = $clog2(QueueDepth + 1);

  front_stat_t     fstat;
  logic [MagW-1:0] seg_peak, q_peak;
  logic [SumW-1:0] seg_sum, q_sum;
  logic [CntW-1:0] seg_cnt, q_cnt;
  logic            seg_ovf, q_ovf;
  logic [QW-1:0]   q_rdata;
  logic            q_empty, q_pop;
  logic [QCW-1:0]  q_count;
  logic            acc;

  assign full = ((QCW+1)'(q_count) + (QCW+1)'(fstat.last_pend)) >= (QCW+1)'(QueueDepth);
  assign acc  = push && !full;

  pcmrms_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .CNT_W      (CntW),
    .SUM_W      (SumW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .in_i      (in_i),
    .stat_o    (fstat),
    .seg_peak_o(seg_peak),
    .seg_sum_o (seg_sum),
    .seg_cnt_o (seg_cnt),
    .seg_ovf_o (seg_ovf)
  );

  pcmrms_queue #(
    .W    (QW),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (fstat.push),
    .wdata_i({seg_peak, seg_sum, seg_cnt, seg_ovf}),
    .rd_i   (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty),
    .count_o(q_count)
  );

  assign {q_peak, q_sum, q_cnt, q_ovf} = q_rdata;

  pcmrms_back #(
    .CNT_W            (CntW),
    .SUM_W            (SumW),
    .RMS_FRACTION_BITS(RMS_FRACTION_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .seg_peak_i(q_peak),
    .seg_sum_i (q_sum),
    .seg_cnt_i (q_cnt),
    .seg_ovf_i (q_ovf),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res_o)
  );

endmodule

// File: hw/rtl/pcmrms_checker.sv
module pcmrms_checker import pcmrms_pkg::*; #(
  parameter int unsigned RMS_FRACTION_BITS = 8
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     empty,
  input logic     pop,
  input pcm_res_t res_o
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("result item changed while stalled");

  a_empty_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.sample_total == 17'd0) |->
      (res_o.peak_level == 16'd0 && res_o.rms_level == 24'd0))
    else $error("empty segment with nonzero level");

  a_peak_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_o.peak_level <= 16'h8000))
    else $error("peak out of range");

  a_rms_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (40'(res_o.rms_level) <= (40'(res_o.peak_level) << RMS_FRACTION_BITS)))
    else $error("rms above peak");

endmodule

bind pcm16_peak_rms_meter_unit pcmrms_checker #(
  .RMS_FRACTION_BITS(RMS_FRACTION_BITS)
) u_pcmrms_checker (.*);
